// ===== rtl/core/sete_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sprite entry tile expander.
// Used by the controller, the datapath and the top level; depends on nothing.
package sete_pkg;

  localparam int unsigned PosW   = 10;
  localparam int unsigned TileXW = 11;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CntW   = 4;
  localparam int unsigned ColorW = 5;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgXOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgYOffset = 1'b1;

  localparam logic [PosW-1:0] XOffsetReset = 10'h3C0;
  localparam logic [PosW-1:0] YOffsetReset = 10'h3F1;

  localparam logic [TileXW-1:0] TileStep = 11'd16;

  localparam logic [1:0] Pri0 = 2'd0;
  localparam logic [1:0] Pri1 = 2'd1;
  localparam logic [1:0] Pri2 = 2'd2;
  localparam logic [1:0] Pri3 = 2'd3;

  typedef enum logic {
    StIdle,
    StEmit
  } sete_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } sete_cmd_t;

  typedef struct packed {
    logic last;
  } sete_sts_t;

  function automatic logic [MaskW-1:0] layer_mask_of(input logic [1:0] pri);
    logic [MaskW-1:0] m;
    unique case (pri)
      Pri0: m = 8'hFE;
      Pri1: m = 8'hF0;
      Pri2: m = 8'hFC;
      Pri3: m = 8'h00;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/sete_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sprite entry tile expander.
// Depends on sete_pkg; drives load and step commands to sete_dp.
module sete_ctrl
  import sete_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sete_sts_t sts_i,
  output sete_cmd_t cmd_o
);

  sete_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic done;
    done        = 1'b0;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        done        = out_ready_i && sts_i.last;
        in_ready_o  = done;
        cmd_o.step  = out_ready_i && !sts_i.last;
        if (done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    cmd_o.load = in_valid_i && in_ready_o;
    if (cmd_o.load) begin
      state_d = StEmit;
    end
  end

endmodule

// ===== rtl/core/sete_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sprite entry tile expander: offset registers, entry decode
// and the per-tile position, code and count registers. Depends on sete_pkg.
module sete_dp
  import sete_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [PosW-1:0]          cfg_data_i,
  input  logic [WordW-1:0]         sprite_x_i,
  input  logic [WordW-1:0]         sprite_y_i,
  input  logic [WordW-1:0]         sprite_code_i,
  input  logic [WordW-1:0]         sprite_attr_i,
  input  logic                     end_of_list_i,
  input  sete_cmd_t                cmd_i,
  output sete_sts_t                sts_o,
  output logic signed [TileXW-1:0] tile_x_o,
  output logic signed [PosW-1:0]   tile_y_o,
  output logic [WordW-1:0]         tile_code_o,
  output logic [ColorW-1:0]        tile_color_o,
  output logic                     flip_horizontal_o,
  output logic                     flip_vertical_o,
  output logic [MaskW-1:0]         priority_mask_o,
  output logic                     last_tile_o,
  output logic                     list_done_o
);

  logic [PosW-1:0]   x_off_q, y_off_q;
  logic [TileXW-1:0] x_q, x_d;
  logic [PosW-1:0]   y_q;
  logic [WordW-1:0]  code_q, code_d;
  logic [ColorW-1:0] color_q;
  logic              flip_x_q, flip_y_q, eol_q;
  logic [MaskW-1:0]  mask_q;
  logic [CntW-1:0]   rem_q, rem_d;

  logic [PosW-1:0]   sx, sy;
  logic [CntW-1:0]   width_m1;
  logic [TileXW-1:0] start_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= XOffsetReset;
      y_off_q <= YOffsetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgXOffset: x_off_q <= cfg_data_i;
        CfgYOffset: y_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sx       = sprite_x_i[PosW-1:0] + x_off_q;
  assign sy       = sprite_y_i[PosW-1:0] + y_off_q;
  assign width_m1 = sprite_attr_i[11:8];
  assign start_x  = {sx[PosW-1], sx}
                  + (sprite_attr_i[5] ? {3'b000, width_m1, 4'b0000} : '0);

  always_comb begin
    x_d    = x_q;
    code_d = code_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      x_d    = start_x;
      code_d = sprite_code_i;
      rem_d  = width_m1;
    end else if (cmd_i.step) begin
      x_d    = flip_x_q ? (x_q - TileStep) : (x_q + TileStep);
      code_d = code_q + 16'd1;
      rem_d  = rem_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    code_q <= code_d;
    rem_q  <= rem_d;
    if (cmd_i.load) begin
      y_q      <= sy;
      color_q  <= sprite_attr_i[4:0];
      flip_x_q <= sprite_attr_i[5];
      flip_y_q <= sprite_attr_i[6];
      mask_q   <= layer_mask_of(sprite_attr_i[13:12]);
      eol_q    <= end_of_list_i;
    end
  end

  assign sts_o.last        = (rem_q == '0);
  assign tile_x_o          = x_q;
  assign tile_y_o          = y_q;
  assign tile_code_o       = code_q;
  assign tile_color_o      = color_q;
  assign flip_horizontal_o = flip_x_q;
  assign flip_vertical_o   = flip_y_q;
  assign priority_mask_o   = mask_q;
  assign last_tile_o       = sts_o.last;
  assign list_done_o       = sts_o.last && eol_q;

endmodule

// ===== rtl/core/sprite_entry_tile_expander.sv =====
`timescale 1ns / 1ps
// Top level of the sprite entry tile expander; joins sete_ctrl and sete_dp.
// Depends on sete_pkg.
//
// The input channel takes one sprite list entry per request: X, Y, code,
// attribute and an end-of-list flag. The entry is expanded into 1 to 16
// tile-draw requests on the output channel, one per cycle while the
// receiver is ready, in tile code order. The first tile appears the cycle
// after the entry is accepted; the tile counter walks one tile at a time.
// A new entry is taken in the same cycle that the last tile of the
// previous entry is taken, so entries follow without a gap.
// When the receiver stalls, the current tile is held and the tile counter
// waits; the input side is not ready until the last tile leaves.
// Reset empties the block and sets the X and Y offsets to -64 and -15.
// The offsets are written through the configuration port while idle;
// the user must keep to this, as the block itself does not enforce it.
module sprite_entry_tile_expander
  import sete_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [PosW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [WordW-1:0]         sprite_x_i,
  input  logic [WordW-1:0]         sprite_y_i,
  input  logic [WordW-1:0]         sprite_code_i,
  input  logic [WordW-1:0]         sprite_attr_i,
  input  logic                     end_of_list_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [TileXW-1:0] tile_x_o,
  output logic signed [PosW-1:0]   tile_y_o,
  output logic [WordW-1:0]         tile_code_o,
  output logic [ColorW-1:0]        tile_color_o,
  output logic                     flip_horizontal_o,
  output logic                     flip_vertical_o,
  output logic [MaskW-1:0]         priority_mask_o,
  output logic                     last_tile_o,
  output logic                     list_done_o
);

  sete_cmd_t cmd;
  sete_sts_t sts;

  sete_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sete_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .sprite_x_i        (sprite_x_i),
    .sprite_y_i        (sprite_y_i),
    .sprite_code_i     (sprite_code_i),
    .sprite_attr_i     (sprite_attr_i),
    .end_of_list_i     (end_of_list_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .tile_x_o          (tile_x_o),
    .tile_y_o          (tile_y_o),
    .tile_code_o       (tile_code_o),
    .tile_color_o      (tile_color_o),
    .flip_horizontal_o (flip_horizontal_o),
    .flip_vertical_o   (flip_vertical_o),
    .priority_mask_o   (priority_mask_o),
    .last_tile_o       (last_tile_o),
    .list_done_o       (list_done_o)
  );

endmodule

// ===== rtl/core/sete_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sprite entry tile expander and its bind.
// Depends on the top level's ports only.
module sete_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] tile_code_o,
  input logic        last_tile_o,
  input logic        list_done_o
);

  a_accept_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted entry produced no tile request");

  a_tiles_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_tile_o |=>
      out_valid_o && (tile_code_o == $past(tile_code_o) + 16'd1))
    else $error("tile sequence broken inside an entry");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_tile_o |-> !in_ready_o)
    else $error("entry taken while tiles remain");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_done_o |-> last_tile_o)
    else $error("list done flagged on a tile that is not last");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tile_code_o))
    else $error("stalled tile request changed");

endmodule

bind sprite_entry_tile_expander sete_checker u_sete_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .tile_code_o (tile_code_o),
  .last_tile_o (last_tile_o),
  .list_done_o (list_done_o)
);
